// ===== rtl/core/mmrm_pkg.sv =====
// Shared types, codes and helpers for the mouse motion rate meter.
package mmrm_pkg;

  localparam int DELTA_BITS  = 16;
  localparam int SUM_BITS    = 32;
  localparam int RATE_BITS   = 20;
  localparam int WTICK_BITS  = 16;
  localparam int REG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;

  // Both queues are two deep; pointers wrap by natural overflow.
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  localparam logic [RATE_BITS-1:0]  RATE_MAX     = '1;
  localparam logic [WTICK_BITS-1:0] WTICK_RESET  = 16'd100;

  localparam logic [REG_IDX_BITS-1:0] REG_ENABLE       = 1'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_TICKS = 1'd1;

  typedef enum logic [1:0] {
    CMD_MOTION = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOTION,
    OP_TICK,
    OP_READ,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t                       kind;
    logic signed [DELTA_BITS-1:0]   dx;
    logic signed [DELTA_BITS-1:0]   dy;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_head_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] offset_x;
    logic signed [SUM_BITS-1:0] offset_y;
    logic [RATE_BITS-1:0]       rate;
    logic [RATE_BITS-1:0]       peak_rate;
    logic                       window_closed;
  } result_t;

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0]   a,
    input logic signed [DELTA_BITS-1:0] b
  );
    logic signed [SUM_BITS:0] s;
    s = {a[SUM_BITS-1], a} + (SUM_BITS+1)'(b);
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      sat_add = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sat_add = s[SUM_BITS-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/mmrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mmrm_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
module mmrm_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [1:0]                             cmd,
  input  logic signed [mmrm_pkg::DELTA_BITS-1:0] delta_x,
  input  logic signed [mmrm_pkg::DELTA_BITS-1:0] delta_y,
  input  logic                                   enable,
  output mmrm_pkg::op_head_t                     head,
  input  logic                                   take
);

  mmrm_pkg::op_t                    q [mmrm_pkg::QDEPTH];
  logic [mmrm_pkg::QPTR_BITS-1:0]   wptr;
  logic [mmrm_pkg::QPTR_BITS-1:0]   rptr;
  logic [mmrm_pkg::QCNT_BITS-1:0]   count;
  mmrm_pkg::op_t                    op_in;
  logic                             accept;

  assign full   = (count == mmrm_pkg::QCNT_BITS'(mmrm_pkg::QDEPTH));
  assign accept = push && !full;

  // Motion and ticks are dropped to no-ops while disabled.
  always_comb begin
    op_in.dx = delta_x;
    op_in.dy = delta_y;
    case (mmrm_pkg::cmd_t'(cmd))
      mmrm_pkg::CMD_MOTION: op_in.kind = enable ? mmrm_pkg::OP_MOTION : mmrm_pkg::OP_NOP;
      mmrm_pkg::CMD_TICK:   op_in.kind = enable ? mmrm_pkg::OP_TICK : mmrm_pkg::OP_NOP;
      mmrm_pkg::CMD_READ:   op_in.kind = mmrm_pkg::OP_READ;
      mmrm_pkg::CMD_CLEAR:  op_in.kind = mmrm_pkg::OP_CLEAR;
      default:              op_in.kind = mmrm_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      case ({accept, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.op    = q[rptr];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mmrm_pkg::QCNT_BITS'(mmrm_pkg::QDEPTH))
    else $error("front queue overfilled");
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    take |-> head.valid)
    else $error("back end took from empty front queue");
`endif

endmodule

// ===== rtl/core/mmrm_back.sv =====
// Back end: executes queued operations, keeps sums and window ring, queues results.
module mmrm_back #(
  parameter int WINDOW_SLOTS = 10,
  parameter int COUNT_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [mmrm_pkg::WTICK_BITS-1:0]        window_ticks,
  input  mmrm_pkg::op_head_t                     head,
  output logic                                   take,
  output logic                                   empty,
  input  logic                                   pop,
  output mmrm_pkg::result_t                      result
);

  localparam int PTR_BITS   = $clog2(WINDOW_SLOTS);
  localparam int TOTAL_BITS = COUNT_BITS + $clog2(WINDOW_SLOTS + 1);
  localparam int CMP_BITS   = (COUNT_BITS > mmrm_pkg::WTICK_BITS) ? COUNT_BITS
                                                                   : mmrm_pkg::WTICK_BITS;
  localparam int SAT_BITS   = (TOTAL_BITS > mmrm_pkg::RATE_BITS) ? TOTAL_BITS
                                                                  : mmrm_pkg::RATE_BITS + 1;

  // Architectural state
  logic signed [mmrm_pkg::SUM_BITS-1:0] sum_x, sum_x_next;
  logic signed [mmrm_pkg::SUM_BITS-1:0] sum_y, sum_y_next;
  logic [COUNT_BITS-1:0]                reports, reports_next;
  logic [COUNT_BITS-1:0]                tick_count, tick_count_next;
  logic [PTR_BITS-1:0]                  slot_ptr, slot_ptr_next;
  logic [WINDOW_SLOTS-1:0]              slot_valid, slot_valid_next;
  logic [TOTAL_BITS-1:0]                window_total, window_total_next;
  logic [mmrm_pkg::RATE_BITS-1:0]       shown_rate, shown_rate_next;
  logic [mmrm_pkg::RATE_BITS-1:0]       peak_value, peak_value_next;

  // Working values
  logic [COUNT_BITS-1:0]                slot_rdata;
  logic [COUNT_BITS-1:0]                slot_old;
  logic [COUNT_BITS-1:0]                tick_inc;
  logic [mmrm_pkg::WTICK_BITS-1:0]      win_len;
  logic [TOTAL_BITS-1:0]                total_upd;
  logic [SAT_BITS-1:0]                  total_ext;
  logic [mmrm_pkg::RATE_BITS-1:0]       rate_upd;
  logic                                 close;
  logic                                 ring_we;
  mmrm_pkg::result_t                    res;

  // Result queue
  mmrm_pkg::result_t                    rq [mmrm_pkg::QDEPTH];
  logic [mmrm_pkg::QPTR_BITS-1:0]       rq_wptr;
  logic [mmrm_pkg::QPTR_BITS-1:0]       rq_rptr;
  logic [mmrm_pkg::QCNT_BITS-1:0]       rq_count;
  logic                                 rq_pop;

  assign take   = head.valid && (rq_count != mmrm_pkg::QCNT_BITS'(mmrm_pkg::QDEPTH));
  assign empty  = (rq_count == '0);
  assign rq_pop = pop && !empty;
  assign result = rq[rq_rptr];

  // Slot at the pointer is prefetched: read address follows the next pointer.
  mmrm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (WINDOW_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_ptr),
    .wdata (reports),
    .raddr (slot_ptr_next),
    .rdata (slot_rdata)
  );

  assign slot_old  = slot_valid[slot_ptr] ? slot_rdata : '0;
  assign tick_inc  = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign win_len   = (window_ticks == '0) ? mmrm_pkg::WTICK_BITS'(1) : window_ticks;
  assign total_upd = (reports == '0) ? '0
                   : window_total - TOTAL_BITS'(slot_old) + TOTAL_BITS'(reports);
  assign total_ext = SAT_BITS'(total_upd);
  assign rate_upd  = (total_ext > SAT_BITS'(mmrm_pkg::RATE_MAX)) ? mmrm_pkg::RATE_MAX
                                                                 : total_ext[mmrm_pkg::RATE_BITS-1:0];

  always_comb begin
    sum_x_next        = sum_x;
    sum_y_next        = sum_y;
    reports_next      = reports;
    tick_count_next   = tick_count;
    slot_ptr_next     = slot_ptr;
    slot_valid_next   = slot_valid;
    window_total_next = window_total;
    shown_rate_next   = shown_rate;
    peak_value_next   = peak_value;
    close             = 1'b0;
    ring_we           = 1'b0;
    res.offset_x      = '0;
    res.offset_y      = '0;

    if (take) begin
      case (head.op.kind)
        mmrm_pkg::OP_MOTION: begin
          sum_x_next   = mmrm_pkg::sat_add(sum_x, head.op.dx);
          sum_y_next   = mmrm_pkg::sat_add(sum_y, head.op.dy);
          reports_next = (reports == '1) ? reports : reports + 1'b1;
        end
        mmrm_pkg::OP_TICK: begin
          tick_count_next = tick_inc;
          if (CMP_BITS'(tick_inc) >= CMP_BITS'(win_len)) begin
            close             = 1'b1;
            ring_we           = 1'b1;
            window_total_next = total_upd;
            if (reports == '0) begin
              slot_valid_next = '0;
            end else begin
              slot_valid_next[slot_ptr] = 1'b1;
            end
            slot_ptr_next = (slot_ptr == PTR_BITS'(WINDOW_SLOTS - 1)) ? '0
                                                                      : slot_ptr + 1'b1;
            shown_rate_next = rate_upd;
            peak_value_next = (rate_upd > peak_value) ? rate_upd : peak_value;
            reports_next    = '0;
            tick_count_next = '0;
          end
        end
        mmrm_pkg::OP_READ: begin
          res.offset_x = sum_x;
          res.offset_y = sum_y;
          sum_x_next   = '0;
          sum_y_next   = '0;
        end
        mmrm_pkg::OP_CLEAR: begin
          sum_x_next      = '0;
          sum_y_next      = '0;
          shown_rate_next = '0;
          peak_value_next = '0;
        end
        default: begin
        end
      endcase
    end

    res.rate          = shown_rate_next;
    res.peak_rate     = peak_value_next;
    res.window_closed = close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      reports      <= '0;
      tick_count   <= '0;
      slot_ptr     <= '0;
      slot_valid   <= '0;
      window_total <= '0;
      shown_rate   <= '0;
      peak_value   <= '0;
    end else begin
      sum_x        <= sum_x_next;
      sum_y        <= sum_y_next;
      reports      <= reports_next;
      tick_count   <= tick_count_next;
      slot_ptr     <= slot_ptr_next;
      slot_valid   <= slot_valid_next;
      window_total <= window_total_next;
      shown_rate   <= shown_rate_next;
      peak_value   <= peak_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rq[rq_wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wptr  <= '0;
      rq_rptr  <= '0;
      rq_count <= '0;
    end else begin
      if (take) begin
        rq_wptr <= rq_wptr + 1'b1;
      end
      if (rq_pop) begin
        rq_rptr <= rq_rptr + 1'b1;
      end
      case ({take, rq_pop})
        2'b10:   rq_count <= rq_count + 1'b1;
        2'b01:   rq_count <= rq_count - 1'b1;
        default: rq_count <= rq_count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_peak_covers_rate: assert property (@(posedge clk) disable iff (rst)
    shown_rate <= peak_value)
    else $error("shown rate above peak");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot_ptr} < (PTR_BITS+1)'(WINDOW_SLOTS))
    else $error("slot pointer out of range");
  a_idle_window_clears: assert property (@(posedge clk) disable iff (rst)
    close && (reports == '0) |=> (window_total == '0) && (slot_valid == '0))
    else $error("empty window did not clear ring");
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_count <= mmrm_pkg::QCNT_BITS'(mmrm_pkg::QDEPTH))
    else $error("result queue overfilled");
`endif

endmodule

// ===== rtl/core/mouse_motion_rate_meter.sv =====
// Top level of the mouse motion rate meter: config registers, front and back ends.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | push / full        | cmd, delta_x, delta_y
//  result   | empty / pop        | offset_x, offset_y, rate, peak_rate,
//           |                    | window_closed
//  config   | write_enable       | reg_index, write_data (0 enable, 1 window_ticks)
//
// One transaction per clock on both sides while full and empty stay low. A command
// accepted into the front queue is executed by the back end once it is at the head
// and the result queue has room; its result is registered into the result queue,
// which drops empty so that the result can be popped.
// Sync reset clears all counters, sums and the ring's valid bits; no clearing
// pass. Ring slot data lives in RAM; the slot at the pointer is prefetched.
// Two-deep queues on each side let push continue while a result waits on pop.
module mouse_motion_rate_meter #(
  parameter int WINDOW_SLOTS = 10,
  parameter int COUNT_BITS   = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // command channel
  input  logic                                      push,
  output logic                                      full,
  input  logic [1:0]                                cmd,
  input  logic signed [mmrm_pkg::DELTA_BITS-1:0]    delta_x,
  input  logic signed [mmrm_pkg::DELTA_BITS-1:0]    delta_y,
  // result channel
  output logic                                      empty,
  input  logic                                      pop,
  output logic signed [mmrm_pkg::SUM_BITS-1:0]      offset_x,
  output logic signed [mmrm_pkg::SUM_BITS-1:0]      offset_y,
  output logic [mmrm_pkg::RATE_BITS-1:0]            rate,
  output logic [mmrm_pkg::RATE_BITS-1:0]            peak_rate,
  output logic                                      window_closed,
  // config write port
  input  logic                                      write_enable,
  input  logic [mmrm_pkg::REG_IDX_BITS-1:0]         reg_index,
  input  logic [mmrm_pkg::CFG_DATA_BITS-1:0]        write_data
);

  logic                              enable;
  logic [mmrm_pkg::WTICK_BITS-1:0]   window_ticks;
  mmrm_pkg::op_head_t                head;
  logic                              take;
  mmrm_pkg::result_t                 result;

  // Config: user writes only while idle (unenforced), so no hazard with queued work.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      window_ticks <= mmrm_pkg::WTICK_RESET;
    end else if (write_enable) begin
      case (reg_index)
        mmrm_pkg::REG_ENABLE:       enable       <= write_data[0];
        mmrm_pkg::REG_WINDOW_TICKS: window_ticks <= write_data[mmrm_pkg::WTICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify (enable folded in here) and queue.
  mmrm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .delta_x (delta_x),
    .delta_y (delta_y),
    .enable  (enable),
    .head    (head),
    .take    (take)
  );

  // Back end: sums, tick counter, window ring, rate/peak, result queue.
  mmrm_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .window_ticks (window_ticks),
    .head         (head),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

  assign offset_x      = result.offset_x;
  assign offset_y      = result.offset_y;
  assign rate          = result.rate;
  assign peak_rate     = result.peak_rate;
  assign window_closed = result.window_closed;

endmodule
